// ----- sv/hpq_pkg.sv -----
`default_nettype none
package hpq_pkg;

   localparam int IdWidth    = 16;
   localparam int PrioWidth  = 32;
   localparam int CountWidth = 11;

   localparam logic [1:0] KIND_PUSH   = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_UPDATE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [IdWidth-1:0]   item_id;
      logic [PrioWidth-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [IdWidth-1:0]    out_id;
      logic [PrioWidth-1:0]  out_priority;
      logic [CountWidth-1:0] entry_count;
      logic                  top_valid;
      logic [IdWidth-1:0]    top_id;
      logic [PrioWidth-1:0]  top_priority;
   } rsp_type;

   typedef struct packed {
      logic [IdWidth-1:0]   id;
      logic [PrioWidth-1:0] prio;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_POP_RD,
      ST_POP_CMP,
      ST_SCAN,
      ST_TOP_RD,
      ST_RESP
   } state_type;

   // true when priority a strictly outranks priority b
   function automatic logic ranks_above(input logic mode,
                                        input logic [PrioWidth-1:0] a,
                                        input logic [PrioWidth-1:0] b);
      ranks_above = mode ? (a < b) : (a > b);
   endfunction

endpackage
`default_nettype wire

// ----- sv/hpq_ram.sv -----
`default_nettype none
module hpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule
`default_nettype wire

// ----- sv/binary_heap_priority_queue_unit.sv -----
`default_nettype none
// Channel   | Ports                        | Handshake
// ----------+------------------------------+------------------------------------
// request   | start, busy, req_payload     | taken when start=1 and busy=0
// response  | rsp_valid, rsp_payload       | one-cycle strobe, cannot be held off
// config    | csr_wr_en, csr_wr_data       | order_mode written when csr_wr_en=1
//
// Request flow: a full push, an empty pop and an unknown kind go straight to
// reading the top and responding; a push places the entry at the end and climbs
// toward the root; a pop takes the root, moves the last entry into the hole and
// sifts it down (a pop of the last entry needs no sift); an update scans every
// entry on one RAM read port for the id, keeps the last match, then sifts the new
// priority down, or up if it does not move down; a missing id reports not found.
// The single heap RAM (two registered reads, one write) paces every step.
// Synchronous reset clears count, order mode and the sequencer; RAM needs none.
// Responses are strobed for one cycle; busy stays high through that strobe.
module binary_heap_priority_queue_unit #(
   parameter int CAPACITY = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire hpq_pkg::req_type req_payload,
   output logic                  rsp_valid,
   output hpq_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data
);
   import hpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   state_type state_ff, state_in;
   entry_type cur_ff, cur_in, out_ff, out_in;
   req_type   req_ff, req_in;
   logic [AW-1:0] pos_ff, pos_in, pidx_ff, pidx_in, fpos_ff, fpos_in;
   logic [CW-1:0] cnt_ff, cnt_in, scan_ff, scan_in;
   logic [1:0]    status_ff, status_in;
   logic          mode_ff, first_ff, first_in, pend_ff, pend_in, found_ff, found_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
   entry_type     wr_data, rd_a, rd_b;
   logic [EntryWidth-1:0] rd_a_raw, rd_b_raw;

   logic [XW-1:0] left_x, right_x, cnt_x;
   logic [AW-1:0] parent;
   logic          left_ok, right_ok, pick_left, pick_right;
   logic [PrioWidth-1:0] best_prio;

   hpq_ram #(.WIDTH(EntryWidth), .DEPTH(CAPACITY)) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a_raw),
      .rd_data_b (rd_b_raw)
   );
   assign rd_a = rd_a_raw;
   assign rd_b = rd_b_raw;

   // child and parent indexes of the hole
   assign left_x   = {1'b0, pos_ff, 1'b1};
   assign right_x  = left_x + XW'(1);
   assign cnt_x    = XW'(cnt_ff);
   assign parent   = (pos_ff - AW'(1)) >> 1;
   assign left_ok  = left_x < cnt_x;
   assign right_ok = right_x < cnt_x;

   // pick the best of hole, left, right; ties go to the hole, then to left
   always_comb begin
      pick_left  = left_ok && ranks_above(mode_ff, rd_a.prio, cur_ff.prio);
      best_prio  = pick_left ? rd_a.prio : cur_ff.prio;
      pick_right = right_ok && ranks_above(mode_ff, rd_b.prio, best_prio);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority case (req_payload.kind)
                  KIND_PUSH:   state_in = (cnt_ff == CapCount) ? ST_TOP_RD : ST_UP_RD;
                  KIND_POP:    state_in = (cnt_ff == '0) ? ST_TOP_RD : ST_POP_RD;
                  KIND_UPDATE: state_in = ST_SCAN;
                  default:     state_in = ST_TOP_RD;
               endcase
            end
         end
         ST_UP_RD:   state_in = (pos_ff == '0) ? ST_TOP_RD : ST_UP_CMP;
         ST_UP_CMP:  state_in = ranks_above(mode_ff, cur_ff.prio, rd_a.prio) ?
                                ST_UP_RD : ST_TOP_RD;
         ST_DN_RD:   state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (pick_left || pick_right) state_in = ST_DN_RD;
            else if (first_ff)           state_in = ST_UP_RD;
            else                         state_in = ST_TOP_RD;
         end
         ST_POP_RD:  state_in = ST_POP_CMP;
         ST_POP_CMP: state_in = (cnt_ff == CW'(1)) ? ST_TOP_RD : ST_DN_RD;
         ST_SCAN: begin
            if (scan_ff >= cnt_ff && !pend_ff) begin
               state_in = found_ff ? ST_DN_RD : ST_TOP_RD;
            end
         end
         ST_TOP_RD:  state_in = ST_RESP;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cur_in    = cur_ff;
      out_in    = out_ff;
      req_in    = req_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      first_in  = first_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      fpos_in   = fpos_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_payload;
               out_in    = '0;
               status_in = STATUS_OK;
               first_in  = 1'b0;
               priority case (req_payload.kind)
                  KIND_PUSH: begin
                     if (cnt_ff == CapCount) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cur_in = '{id: req_payload.item_id, prio: req_payload.item_priority};
                        pos_in = cnt_ff[AW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  KIND_POP: begin
                     if (cnt_ff == '0) status_in = STATUS_EMPTY;
                  end
                  KIND_UPDATE: begin
                     scan_in  = '0;
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_UP_RD: begin
            // at the root: drop the entry into the hole
            if (pos_ff == '0) wr_en = 1'b1;
            rd_addr_a = parent;
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (ranks_above(mode_ff, cur_ff.prio, rd_a.prio)) begin
               wr_data = rd_a;
               pos_in  = parent;
            end
         end
         ST_DN_RD: begin
            rd_addr_a = left_x[AW-1:0];
            rd_addr_b = right_x[AW-1:0];
         end
         ST_DN_CMP: begin
            if (pick_right) begin
               wr_en   = 1'b1;
               wr_data = rd_b;
               pos_in  = right_x[AW-1:0];
               first_in = 1'b0;
            end else if (pick_left) begin
               wr_en   = 1'b1;
               wr_data = rd_a;
               pos_in  = left_x[AW-1:0];
               first_in = 1'b0;
            end else if (first_ff) begin
               first_in = 1'b0;
            end else begin
               wr_en = 1'b1;
            end
         end
         ST_POP_RD: begin
            rd_addr_a = '0;
            rd_addr_b = AW'(cnt_ff - CW'(1));
         end
         ST_POP_CMP: begin
            out_in = rd_a;
            cur_in = rd_b;
            cnt_in = cnt_ff - CW'(1);
            pos_in = '0;
         end
         ST_SCAN: begin
            rd_addr_a = scan_ff[AW-1:0];
            pend_in   = scan_ff < cnt_ff;
            pidx_in   = scan_ff[AW-1:0];
            if (scan_ff < cnt_ff) scan_in = scan_ff + CW'(1);
            // keep the last match
            if (pend_ff && rd_a.id == req_ff.item_id) begin
               found_in = 1'b1;
               fpos_in  = pidx_ff;
            end
            if (scan_ff >= cnt_ff && !pend_ff) begin
               if (found_ff) begin
                  cur_in   = '{id: req_ff.item_id, prio: req_ff.item_priority};
                  pos_in   = fpos_ff;
                  first_in = 1'b1;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
         end
         ST_TOP_RD: rd_addr_a = '0;
         ST_RESP: ;
         default: ;
      endcase
   end

   // response drive
   always_comb begin
      busy        = state_ff != ST_IDLE;
      rsp_valid   = state_ff == ST_RESP;
      rsp_payload.status       = status_ff;
      rsp_payload.out_id       = out_ff.id;
      rsp_payload.out_priority = out_ff.prio;
      rsp_payload.entry_count  = CountWidth'(cnt_ff);
      rsp_payload.top_valid    = cnt_ff != '0;
      rsp_payload.top_id       = (cnt_ff != '0) ? rd_a.id : '0;
      rsp_payload.top_priority = (cnt_ff != '0) ? rd_a.prio : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         first_ff <= first_in;
         if (csr_wr_en) mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      out_ff    <= out_in;
      req_ff    <= req_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      scan_ff   <= scan_in;
      pidx_ff   <= pidx_in;
      fpos_ff   <= fpos_in;
   end
endmodule
`default_nettype wire
